// ===== rtl/core/ecpa_pkg.sv =====
package ecpa_pkg;

  // Operations of the shared modular unit
  typedef enum logic [1:0] {
    ALU_MAC,     // (2*acc + bit*b) mod m, one multiplier bit per cycle
    ALU_EUCLID,  // division step on the remainder, MAC with the quotient bit
    ALU_ADD,     // (acc + b) mod m
    ALU_SUB      // (acc - b) mod m
  } alu_op_e;

  typedef struct packed {
    alu_op_e op;
    logic    mac_bit;
  } alu_ctl_t;

  // Sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED,    // reduce the five operands modulo p
    ST_DSQ,    // xp * xp
    ST_DNUM1,  // 2 * xp^2
    ST_DNUM2,  // 3 * xp^2
    ST_DNUM3,  // 3 * xp^2 + a
    ST_DDEN,   // 2 * yp
    ST_ANUM,   // yq - yp
    ST_ADEN,   // xq - xp
    ST_ELOOP,  // Euclid: test remainder
    ST_EDIV,   // Euclid: quotient bits and q * t1
    ST_EUPD,   // Euclid: shift remainders and coefficients
    ST_SLOPE,  // num * inv
    ST_SSQ,    // s * s
    ST_XR1,    // s^2 - xp
    ST_XR2,    // s^2 - xp - xq
    ST_DIFF,   // xp - xr
    ST_YR1,    // s * (xp - xr)
    ST_YR2,    // s * (xp - xr) - yp
    ST_DONE
  } step_e;

  // Operand select during reduction
  localparam logic [2:0] RED_XP = 3'd0;
  localparam logic [2:0] RED_YP = 3'd1;
  localparam logic [2:0] RED_XQ = 3'd2;
  localparam logic [2:0] RED_YQ = 3'd3;
  localparam logic [2:0] RED_A  = 3'd4;

  typedef struct packed {
    logic start;
    logic ack;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

// ===== rtl/core/ecc_point_add_double_mod_p.sv =====
// Elliptic curve point add / double over GF(p), one result per request.
// Input stream: s_axis_tdata carries xp, yp, xq, yq, prime, coef_a (each
// COORD_BITS wide, zero padded to whole bytes); s_axis_tuser selects the
// operation (0 add, 1 double, where xq and yq are ignored).
// Output stream: m_axis_tdata carries xr, yr; m_axis_tuser is the invalid
// flag, set with zero coordinates when the slope denominator has no inverse
// or the modulus is below two.
// All arithmetic runs through one modular unit under a step sequencer; a
// multiply handles one multiplier bit per cycle and the inverse is an
// extended Euclid loop with one quotient bit per cycle.
// A modulus below two skips the arithmetic and goes straight to the result.
// s_axis_tready is high only while the sequencer is idle, so one request is
// in flight at a time.
// The result moves into an output register; while the receiver stalls, the
// sequencer holds the next result and a new request is taken only after
// that result has been handed to the output register.
// Reset empties the output register and returns the sequencer to idle.
module ecc_point_add_double_mod_p #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // fields from bit 0: xp, yp, xq, yq, prime, coef_a, zero padding
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // operation: 0 add, 1 double
  input  logic                                    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // fields from bit 0: xr, yr, zero padding
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // invalid flag
  output logic                                    m_axis_tuser
);
  import ecpa_pkg::*;

  localparam int unsigned W           = COORD_BITS;
  localparam int unsigned OUT_TDATA_W = ((2*COORD_BITS+7)/8)*8;

  seq_ctl_t     seq_ctl;
  seq_stat_t    seq_stat;
  logic [W-1:0] res_xr;
  logic [W-1:0] res_yr;
  logic         res_invalid;
  logic         out_valid_q;
  logic [W-1:0] out_xr_q;
  logic [W-1:0] out_yr_q;
  logic         out_invalid_q;

  // Accept a request only while idle; hand off once the output slot frees
  assign s_axis_tready = seq_stat.idle;
  assign seq_ctl.start = s_axis_tvalid & seq_stat.idle;
  assign seq_ctl.ack   = seq_stat.done & (~out_valid_q | m_axis_tready);

  ecpa_seq #(.W(W)) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (seq_ctl),
    .dbl_i     (s_axis_tuser),
    .xp_i      (s_axis_tdata[0*W +: W]),
    .yp_i      (s_axis_tdata[1*W +: W]),
    .xq_i      (s_axis_tdata[2*W +: W]),
    .yq_i      (s_axis_tdata[3*W +: W]),
    .prime_i   (s_axis_tdata[4*W +: W]),
    .coef_a_i  (s_axis_tdata[5*W +: W]),
    .stat_o    (seq_stat),
    .xr_o      (res_xr),
    .yr_o      (res_yr),
    .invalid_o (res_invalid)
  );

  // Output register: load on handoff, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_ctl.ack) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ctl.ack) begin
      out_xr_q      <= res_xr;
      out_yr_q      <= res_yr;
      out_invalid_q <= res_invalid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_yr_q, out_xr_q});
  assign m_axis_tuser  = out_invalid_q;

endmodule

// ===== rtl/core/ecpa_alu.sv =====
module ecpa_alu #(
  parameter int unsigned W = 6
) (
  input  ecpa_pkg::alu_ctl_t ctl_i,
  input  logic [W-1:0]       acc_i,
  input  logic [W-1:0]       b_i,
  input  logic [W-1:0]       m_i,
  input  logic [W-1:0]       rem_i,
  input  logic [W-1:0]       div_i,
  input  logic               dvd_bit_i,
  output logic [W-1:0]       res_o,
  output logic [W-1:0]       rem_o
);
  import ecpa_pkg::*;

  logic [W:0]   rem_sh;
  logic [W:0]   rem_diff;
  logic         qbit;
  logic         add_bit;
  logic [W+1:0] m_ext;
  logic [W+1:0] sum;
  logic [W+1:0] s1;
  logic [W+1:0] s2;

  // Restoring division step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_i, dvd_bit_i};
    rem_diff = rem_sh - {1'b0, div_i};
    qbit     = (rem_sh >= {1'b0, div_i});
    rem_o    = qbit ? rem_diff[W-1:0] : rem_sh[W-1:0];
  end

  // Modular add, subtract or double-and-add; the raw sum stays below 3m
  always_comb begin
    add_bit = (ctl_i.op == ALU_EUCLID) ? qbit : ctl_i.mac_bit;
    m_ext   = {2'b00, m_i};
    unique case (ctl_i.op) inside
      ALU_MAC, ALU_EUCLID: sum = {1'b0, acc_i, 1'b0} + (add_bit ? {2'b00, b_i} : '0);
      ALU_ADD:             sum = {2'b00, acc_i} + {2'b00, b_i};
      ALU_SUB:             sum = {2'b00, acc_i} + m_ext - {2'b00, b_i};
      default:             sum = '0;
    endcase
    s1    = (sum >= m_ext) ? sum - m_ext : sum;
    s2    = (s1 >= m_ext) ? s1 - m_ext : s1;
    res_o = s2[W-1:0];
  end

endmodule

// ===== rtl/core/ecpa_seq.sv =====
module ecpa_seq #(
  parameter int unsigned W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ecpa_pkg::seq_ctl_t  ctl_i,
  input  logic                dbl_i,
  input  logic [W-1:0]        xp_i,
  input  logic [W-1:0]        yp_i,
  input  logic [W-1:0]        xq_i,
  input  logic [W-1:0]        yq_i,
  input  logic [W-1:0]        prime_i,
  input  logic [W-1:0]        coef_a_i,
  output ecpa_pkg::seq_stat_t stat_o,
  output logic [W-1:0]        xr_o,
  output logic [W-1:0]        yr_o,
  output logic                invalid_o
);
  import ecpa_pkg::*;

  localparam int unsigned     CW      = $clog2(W);
  localparam logic [CW-1:0]   CNT_TOP = CW'(W - 1);
  localparam logic [W-1:0]    ONE     = W'(1);
  localparam logic [W-1:0]    TWO     = W'(2);

  step_e         step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [2:0]    red_idx_q, red_idx_d;
  logic          dbl_q, dbl_d;
  logic          invalid_q, invalid_d;
  logic [W-1:0]  m_q, m_d;
  logic [W-1:0]  xp_q, xp_d, yp_q, yp_d, xq_q, xq_d, yq_q, yq_d, a_q, a_d;
  logic [W-1:0]  num_q, num_d, s_q, s_d, tmp_q, tmp_d;
  logic [W-1:0]  r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d, rem_q, rem_d;
  logic [W-1:0]  xr_q, xr_d, yr_q, yr_d;

  alu_ctl_t      alu_ctl;
  logic [W-1:0]  alu_acc;
  logic [W-1:0]  alu_b;
  logic [W-1:0]  alu_res;
  logic [W-1:0]  alu_rem;
  logic          mac_last;
  logic [CW-1:0] cnt_step;
  logic [W-1:0]  red_src;

  ecpa_alu #(.W(W)) u_alu (
    .ctl_i     (alu_ctl),
    .acc_i     (alu_acc),
    .b_i       (alu_b),
    .m_i       (m_q),
    .rem_i     (rem_q),
    .div_i     (r1_q),
    .dvd_bit_i (r0_q[cnt_q]),
    .res_o     (alu_res),
    .rem_o     (alu_rem)
  );

  assign mac_last = (cnt_q == '0);
  assign cnt_step = mac_last ? CNT_TOP : cnt_q - 1'b1;

  // Pick the raw operand under reduction
  always_comb begin
    unique case (red_idx_q)
      RED_XP:  red_src = xp_q;
      RED_YP:  red_src = yp_q;
      RED_XQ:  red_src = xq_q;
      RED_YQ:  red_src = yq_q;
      RED_A:   red_src = a_q;
      default: red_src = a_q;
    endcase
  end

  // Step sequencing and operand routing to the shared unit
  always_comb begin
    step_d    = step_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    red_idx_d = red_idx_q;
    dbl_d     = dbl_q;
    invalid_d = invalid_q;
    m_d       = m_q;
    xp_d      = xp_q;
    yp_d      = yp_q;
    xq_d      = xq_q;
    yq_d      = yq_q;
    a_d       = a_q;
    num_d     = num_q;
    s_d       = s_q;
    tmp_d     = tmp_q;
    r0_d      = r0_q;
    r1_d      = r1_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    rem_d     = rem_q;
    xr_d      = xr_q;
    yr_d      = yr_q;
    alu_ctl   = '{op: ALU_MAC, mac_bit: 1'b0};
    alu_acc   = acc_q;
    alu_b     = '0;

    unique case (step_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          dbl_d     = dbl_i;
          m_d       = prime_i;
          xp_d      = xp_i;
          yp_d      = yp_i;
          xq_d      = xq_i;
          yq_d      = yq_i;
          a_d       = coef_a_i;
          xr_d      = '0;
          yr_d      = '0;
          red_idx_d = RED_XP;
          invalid_d = (prime_i < TWO);
          step_d    = (prime_i < TWO) ? ST_DONE : ST_RED;
        end
      end

      ST_RED: begin
        alu_b           = ONE;
        alu_ctl.mac_bit = red_src[cnt_q];
        cnt_d           = cnt_step;
        acc_d           = alu_res;
        if (mac_last) begin
          acc_d = '0;
          unique case (red_idx_q)
            RED_XP:  xp_d = alu_res;
            RED_YP:  yp_d = alu_res;
            RED_XQ:  xq_d = alu_res;
            RED_YQ:  yq_d = alu_res;
            RED_A:   a_d  = alu_res;
            default: ;
          endcase
          if (red_idx_q == RED_A) begin
            // Doubling takes Q equal to P
            if (dbl_q) begin
              xq_d = xp_q;
            end
            step_d = dbl_q ? ST_DSQ : ST_ANUM;
          end else begin
            red_idx_d = red_idx_q + 3'd1;
          end
        end
      end

      ST_DSQ: begin
        alu_b           = xp_q;
        alu_ctl.mac_bit = xp_q[cnt_q];
        cnt_d           = cnt_step;
        acc_d           = mac_last ? '0 : alu_res;
        if (mac_last) begin
          tmp_d  = alu_res;
          step_d = ST_DNUM1;
        end
      end

      ST_DNUM1: begin
        alu_ctl.op = ALU_ADD;
        alu_acc    = tmp_q;
        alu_b      = tmp_q;
        num_d      = alu_res;
        step_d     = ST_DNUM2;
      end

      ST_DNUM2: begin
        alu_ctl.op = ALU_ADD;
        alu_acc    = num_q;
        alu_b      = tmp_q;
        num_d      = alu_res;
        step_d     = ST_DNUM3;
      end

      ST_DNUM3: begin
        alu_ctl.op = ALU_ADD;
        alu_acc    = num_q;
        alu_b      = a_q;
        num_d      = alu_res;
        step_d     = ST_DDEN;
      end

      ST_DDEN: begin
        alu_ctl.op = ALU_ADD;
        alu_acc    = yp_q;
        alu_b      = yp_q;
        r1_d       = alu_res;
        r0_d       = m_q;
        t0_d       = '0;
        t1_d       = ONE;
        step_d     = ST_ELOOP;
      end

      ST_ANUM: begin
        alu_ctl.op = ALU_SUB;
        alu_acc    = yq_q;
        alu_b      = yp_q;
        num_d      = alu_res;
        step_d     = ST_ADEN;
      end

      ST_ADEN: begin
        alu_ctl.op = ALU_SUB;
        alu_acc    = xq_q;
        alu_b      = xp_q;
        r1_d       = alu_res;
        r0_d       = m_q;
        t0_d       = '0;
        t1_d       = ONE;
        step_d     = ST_ELOOP;
      end

      // Stop once the remainder is zero; gcd of one means t0 is the inverse
      ST_ELOOP: begin
        if (r1_q == '0) begin
          if (r0_q == ONE) begin
            step_d = ST_SLOPE;
          end else begin
            invalid_d = 1'b1;
            step_d    = ST_DONE;
          end
        end else begin
          acc_d  = '0;
          rem_d  = '0;
          step_d = ST_EDIV;
        end
      end

      // Quotient bits come MSB first and feed q * t1 mod p directly
      ST_EDIV: begin
        alu_ctl.op = ALU_EUCLID;
        alu_b      = t1_q;
        acc_d      = alu_res;
        rem_d      = alu_rem;
        cnt_d      = cnt_step;
        if (mac_last) begin
          step_d = ST_EUPD;
        end
      end

      ST_EUPD: begin
        alu_ctl.op = ALU_SUB;
        alu_acc    = t0_q;
        alu_b      = acc_q;
        t1_d       = alu_res;
        t0_d       = t1_q;
        r0_d       = r1_q;
        r1_d       = rem_q;
        acc_d      = '0;
        step_d     = ST_ELOOP;
      end

      ST_SLOPE: begin
        alu_b           = num_q;
        alu_ctl.mac_bit = t0_q[cnt_q];
        cnt_d           = cnt_step;
        acc_d           = mac_last ? '0 : alu_res;
        if (mac_last) begin
          s_d    = alu_res;
          step_d = ST_SSQ;
        end
      end

      ST_SSQ: begin
        alu_b           = s_q;
        alu_ctl.mac_bit = s_q[cnt_q];
        cnt_d           = cnt_step;
        acc_d           = mac_last ? '0 : alu_res;
        if (mac_last) begin
          tmp_d  = alu_res;
          step_d = ST_XR1;
        end
      end

      ST_XR1: begin
        alu_ctl.op = ALU_SUB;
        alu_acc    = tmp_q;
        alu_b      = xp_q;
        tmp_d      = alu_res;
        step_d     = ST_XR2;
      end

      ST_XR2: begin
        alu_ctl.op = ALU_SUB;
        alu_acc    = tmp_q;
        alu_b      = xq_q;
        xr_d       = alu_res;
        step_d     = ST_DIFF;
      end

      ST_DIFF: begin
        alu_ctl.op = ALU_SUB;
        alu_acc    = xp_q;
        alu_b      = xr_q;
        tmp_d      = alu_res;
        step_d     = ST_YR1;
      end

      ST_YR1: begin
        alu_b           = s_q;
        alu_ctl.mac_bit = tmp_q[cnt_q];
        cnt_d           = cnt_step;
        acc_d           = mac_last ? '0 : alu_res;
        if (mac_last) begin
          tmp_d  = alu_res;
          step_d = ST_YR2;
        end
      end

      ST_YR2: begin
        alu_ctl.op = ALU_SUB;
        alu_acc    = tmp_q;
        alu_b      = yp_q;
        yr_d       = alu_res;
        step_d     = ST_DONE;
      end

      // Hold the result until the output register takes it
      ST_DONE: begin
        if (ctl_i.ack) begin
          step_d = ST_IDLE;
        end
      end

      default: step_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      cnt_q  <= CNT_TOP;
      acc_q  <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    red_idx_q <= red_idx_d;
    dbl_q     <= dbl_d;
    invalid_q <= invalid_d;
    m_q       <= m_d;
    xp_q      <= xp_d;
    yp_q      <= yp_d;
    xq_q      <= xq_d;
    yq_q      <= yq_d;
    a_q       <= a_d;
    num_q     <= num_d;
    s_q       <= s_d;
    tmp_q     <= tmp_d;
    r0_q      <= r0_d;
    r1_q      <= r1_d;
    t0_q      <= t0_d;
    t1_q      <= t1_d;
    rem_q     <= rem_d;
    xr_q      <= xr_d;
    yr_q      <= yr_d;
  end

  assign stat_o.idle = (step_q == ST_IDLE);
  assign stat_o.done = (step_q == ST_DONE);
  assign xr_o        = xr_q;
  assign yr_o        = yr_q;
  assign invalid_o   = invalid_q;

`ifndef SYNTH
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_EDIV) |-> (r1_q != '0))
    else $error("division step with zero divisor");

  a_acc_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_IDLE && step_q != ST_DONE) |-> (acc_q < m_q))
    else $error("accumulator not reduced modulo p");

  a_coef_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_ELOOP) |-> (t0_q < m_q && t1_q < m_q))
    else $error("Euclid coefficients not reduced modulo p");

  a_ack_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_DONE && ctl_i.ack) |=> (step_q == ST_IDLE))
    else $error("sequencer did not release after handoff");
`endif

endmodule

// ===== tb/ecc_point_add_double_mod_p_tb.sv =====
`timescale 1ns / 1ps

module ecc_point_add_double_mod_p_tb;

  localparam int unsigned CB = 6;
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_DOUBLE = 1'b1;

  localparam int N_DIRECTED   = 19;
  localparam int N_RANDOM     = 2000;
  localparam int CALM_FIRST   = 1000;
  localparam int CALM_LAST    = 1300;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic          op;
    logic [CB-1:0] xp;
    logic [CB-1:0] yp;
    logic [CB-1:0] xq;
    logic [CB-1:0] yq;
    logic [CB-1:0] prime;
    logic [CB-1:0] coef_a;
  } point_req_t;

  typedef struct packed {
    logic [CB-1:0] xr;
    logic [CB-1:0] yr;
    logic          invalid;
  } point_res_t;

  typedef struct packed {
    point_req_t req;
    logic       typed;  // want below holds the typed-in answer
    point_res_t want;
  } point_row_t;

  localparam point_res_t NO_INVERSE = '{xr: '0, yr: '0, invalid: 1'b1};
  localparam point_res_t UNTYPED    = '0;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [39:0]   s_axis_tdata;
  logic          s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [15:0]   m_axis_tdata;
  logic          m_axis_tuser;

  point_res_t expected_points [$];
  int         results_seen;
  int         mismatches;
  int         stall_cycles;
  bit         hold_done;

  int primes [18] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61};

  // op, xp, yp, xq, yq, prime, coef_a; typed; xr, yr, invalid
  point_row_t point_rows [N_DIRECTED] = '{
    '{'{OP_ADD,    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},  1'b1, NO_INVERSE},
    '{'{OP_DOUBLE, 6'd63, 6'd63, 6'd63, 6'd63, 6'd1,  6'd63}, 1'b1, NO_INVERSE},
    '{'{OP_ADD,    6'd3,  6'd4,  6'd3,  6'd7,  6'd11, 6'd1},  1'b1, NO_INVERSE},
    '{'{OP_DOUBLE, 6'd5,  6'd0,  6'd9,  6'd9,  6'd13, 6'd2},  1'b1, NO_INVERSE},
    '{'{OP_ADD,    6'd2,  6'd1,  6'd5,  6'd4,  6'd9,  6'd0},  1'b1, NO_INVERSE},
    '{'{OP_DOUBLE, 6'd1,  6'd1,  6'd0,  6'd0,  6'd2,  6'd1},  1'b1, NO_INVERSE},
    '{'{OP_ADD,    6'd1,  6'd3,  6'd12, 6'd9,  6'd11, 6'd4},  1'b1, NO_INVERSE},
    '{'{OP_ADD,    6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, NO_INVERSE},
    '{'{OP_ADD,    6'd0,  6'd7,  6'd3,  6'd1,  6'd63, 6'd5},  1'b1, NO_INVERSE},
    '{'{OP_DOUBLE, 6'd1,  6'd1,  6'd2,  6'd2,  6'd4,  6'd0},  1'b1, NO_INVERSE},
    '{'{OP_ADD,    6'd0,  6'd0,  6'd0,  6'd0,  6'd5,  6'd0},  1'b1, NO_INVERSE},
    '{'{OP_ADD,    6'd1,  6'd2,  6'd60, 6'd59, 6'd61, 6'd5},  1'b0, UNTYPED},
    '{'{OP_DOUBLE, 6'd60, 6'd60, 6'd0,  6'd0,  6'd61, 6'd60}, 1'b0, UNTYPED},
    '{'{OP_DOUBLE, 6'd63, 6'd63, 6'd63, 6'd63, 6'd61, 6'd63}, 1'b0, UNTYPED},
    '{'{OP_ADD,    6'd0,  6'd1,  6'd1,  6'd2,  6'd3,  6'd0},  1'b0, UNTYPED},
    '{'{OP_DOUBLE, 6'd2,  6'd1,  6'd0,  6'd0,  6'd3,  6'd2},  1'b0, UNTYPED},
    '{'{OP_DOUBLE, 6'd5,  6'd1,  6'd63, 6'd63, 6'd17, 6'd2},  1'b0, UNTYPED},
    '{'{OP_ADD,    6'd0,  6'd7,  6'd2,  6'd1,  6'd63, 6'd5},  1'b0, UNTYPED},
    '{'{OP_ADD,    6'd58, 6'd0,  6'd0,  6'd58, 6'd59, 6'd0},  1'b0, UNTYPED}
  };

  ecc_point_add_double_mod_p #(
    .COORD_BITS(CB)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Slope, then R = P + Q or R = 2P; no inverse gives invalid with zero coordinates
  function automatic point_res_t point_op_result(point_req_t r);
    point_res_t res;
    int m, xp, yp, xq, yq, a, num, den, inv, s, x3, y3;
    res = NO_INVERSE;
    m = int'(r.prime);
    if (m < 2) return res;
    xp = int'(r.xp) % m;
    yp = int'(r.yp) % m;
    xq = int'(r.xq) % m;
    yq = int'(r.yq) % m;
    a  = int'(r.coef_a) % m;
    if (r.op == OP_DOUBLE) begin
      xq  = xp;
      num = (3 * xp * xp + a) % m;
      den = (2 * yp) % m;
    end else begin
      num = (yq - yp + m) % m;
      den = (xq - xp + m) % m;
    end
    // search the inverse; none exists for zero or a shared factor
    inv = 0;
    for (int i = 1; i < m; i++) begin
      if ((den * i) % m == 1) inv = i;
    end
    if (inv == 0) return res;
    s  = (num * inv) % m;
    x3 = ((s * s - xp - xq) % m + m) % m;
    y3 = ((s * ((xp - x3 + m) % m) - yp) % m + m) % m;
    res.xr      = x3[CB-1:0];
    res.yr      = y3[CB-1:0];
    res.invalid = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Offer one request, after a random gap unless eager, hold it until taken, then log its answer
  task automatic send_point_op(input point_req_t r, input point_res_t want, input bit eager);
    int gap;
    gap = 0;
    if (!eager) begin
      while ($urandom_range(99) < 33) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {4'b0, r.coef_a, r.prime, r.yq, r.xq, r.yp, r.xp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_points.push_back(want);
  endtask

  // Main sequence: reset, directed table, random requests, drain
  initial begin
    point_req_t  req;
    int          pick;
    logic [63:0] noise;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (point_rows[i]) begin
      send_point_op(point_rows[i].req,
                    point_rows[i].typed ? point_rows[i].want
                                        : point_op_result(point_rows[i].req), 1'b0);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      req.op     = 1'($urandom_range(1));
      req.prime  = CB'(primes[$urandom_range(17)]);
      req.xp     = CB'($urandom_range(req.prime - 1));
      req.yp     = CB'($urandom_range(req.prime - 1));
      req.xq     = CB'($urandom_range(req.prime - 1));
      req.yq     = CB'($urandom_range(req.prime - 1));
      req.coef_a = CB'($urandom_range(req.prime - 1));
      pick = $urandom_range(99);
      // operands above the modulus
      if (pick >= 70 && pick < 85) begin
        req.xp     = CB'($urandom_range(63));
        req.yp     = CB'($urandom_range(63));
        req.xq     = CB'($urandom_range(63));
        req.yq     = CB'($urandom_range(63));
        req.coef_a = CB'($urandom_range(63));
      end
      // raw noise, any modulus
      if (pick >= 85) begin
        noise = {$urandom, $urandom};
        req   = noise[36:0];
      end
      send_point_op(req, point_op_result(req), n >= CALM_FIRST && n < CALM_LAST);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, one calm stretch
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 33);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    point_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected, xr", int'(m_axis_tdata[CB-1:0]), 0);
      end else begin
        want = expected_points.pop_front();
        if (m_axis_tdata[CB-1:0] !== want.xr)
          report_mismatch("xr", int'(m_axis_tdata[CB-1:0]), int'(want.xr));
        if (m_axis_tdata[2*CB-1:CB] !== want.yr)
          report_mismatch("yr", int'(m_axis_tdata[2*CB-1:CB]), int'(want.yr));
        if (m_axis_tuser !== want.invalid)
          report_mismatch("invalid", int'(m_axis_tuser), int'(want.invalid));
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/ecpa_pkg.sv
rtl/core/ecpa_alu.sv
rtl/core/ecpa_seq.sv
rtl/core/ecc_point_add_double_mod_p.sv
tb/ecc_point_add_double_mod_p_tb.sv
